### design/crs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int SOL_WIDTH      = 32;
  localparam int THR_WIDTH      = 32;
  localparam int ORDER_WIDTH    = 2;
  localparam int FRAC_BITS      = 16;
  localparam logic [0:0] REG_ORDER = 1'b0;
  localparam logic [0:0] REG_THR   = 1'b1;

  // Job handed from the row collector to the solver.
  typedef struct packed {
    logic three;
  } job_ctl_t;
endpackage
`default_nettype wire

### design/crs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Row collector: stores rows, emits a solve job when a system is complete.
module crs_front #(
  parameter int CW = crs_pkg::COEF_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_fire,
  input  wire  [4*CW-1:0]                in_row,
  input  wire  [crs_pkg::ORDER_WIDTH-1:0] order,
  output logic                           job_valid,
  input  wire                            job_ready,
  output crs_pkg::job_ctl_t              job_ctl,
  output logic [12*CW-1:0]               job_rows,
  output logic                           front_ready
);
  logic [4*CW-1:0] rows_r [3];
  logic [1:0] cnt_r, cnt_nxt, ridx;
  logic       jv_r, jv_nxt, last, three;
  crs_pkg::job_ctl_t jc_r;

  assign three = (order == 2'd3);
  assign ridx  = (cnt_r > 2'd2) ? 2'd2 : cnt_r;
  assign last  = three ? (ridx == 2'd2) : (ridx >= 2'd1);
  // While a job waits unclaimed the row store is frozen.
  assign front_ready = !jv_r;

  always_comb begin
    cnt_nxt = cnt_r;
    jv_nxt  = jv_r;
    if (jv_r && job_ready) jv_nxt = 1'b0;
    if (in_fire) begin
      if (last) begin
        cnt_nxt = 2'd0;
        jv_nxt  = 1'b1;
      end else begin
        cnt_nxt = ridx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      jv_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      jv_r  <= jv_nxt;
    end
    if (in_fire) begin
      rows_r[ridx] <= in_row;
      if (last) jc_r.three <= three;
    end
  end

  assign job_valid = jv_r;
  assign job_ctl   = jc_r;
  assign job_rows  = {rows_r[2], rows_r[1], rows_r[0]};
endmodule
`default_nettype wire

### design/crs_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle, magnitude only.
module crs_divider #(
  parameter int NW = 72,
  parameter int QW = 34
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  input  wire  [NW-1:0]  num,
  input  wire  [NW-1:0]  den,
  output logic           busy,
  output logic [QW-1:0]  quo,
  output logic           big
);
  localparam int CNTW = $clog2(NW + 1);
  logic [NW-1:0]   rem_r, num_r, den_r;
  logic [QW-1:0]   q_r;
  logic            big_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic [NW:0]     sh, diff;

  assign sh   = {rem_r, num_r[NW-1]};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CNTW'(1)) begin
      busy_r <= 1'b0;
    end
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
      q_r   <= '0;
      big_r <= 1'b0;
      cnt_r <= CNTW'(NW);
    end else if (busy_r) begin
      num_r <= num_r << 1;
      cnt_r <= cnt_r - CNTW'(1);
      big_r <= big_r | q_r[QW-1];
      if (!diff[NW]) begin
        rem_r <= diff[NW-1:0];
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= sh[NW-1:0];
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;
  assign big  = big_r;
endmodule
`default_nettype wire

### design/crs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Solver: sequences determinant minors and products, then divides.
module crs_back #(
  parameter int CW = crs_pkg::COEF_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            job_valid,
  output logic                           job_ready,
  input  crs_pkg::job_ctl_t              job_ctl,
  input  wire  [12*CW-1:0]               job_rows,
  input  wire  [crs_pkg::THR_WIDTH-1:0]  thr,
  output logic                           res_valid,
  input  wire                            res_ready,
  output logic [3*crs_pkg::SOL_WIDTH+1:0] res_data
);
  localparam int PW = 2*CW + 1;         // 2x2 minor
  localparam int DW = 3*CW + 4;         // 3x3 determinant
  localparam int NW = DW + crs_pkg::FRAC_BITS;
  localparam int SW = crs_pkg::SOL_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0, S_MIN = 3'd1, S_DET = 3'd2,
                         S_CHK = 3'd3, S_DIV = 3'd4, S_WAIT = 3'd5, S_OUT = 3'd6;

  logic [2:0] st_r;
  logic [1:0] rep_r;     // 3 = no replacement
  logic [1:0] ph_r;      // term index
  logic       three_r;
  logic [12*CW-1:0] rows_r;
  logic signed [PW-1:0] minor_r;
  logic signed [DW-1:0] acc_r, d_r;
  logic signed [DW-1:0] dj_r [3];
  logic [SW-1:0] sol_r [3];
  logic sing_r, ovf_r;
  logic [1:0] k_r;
  logic rv_r;

  function automatic logic signed [CW-1:0] el(input logic [12*CW-1:0] rw,
      input logic [1:0] r, input logic [1:0] c, input logic [1:0] rep);
    logic [1:0] cc;
    cc = (c == rep) ? 2'd3 : c;
    return rw[(4*r + cc)*CW +: CW];
  endfunction

  // term p of 3x3: a0p * minor(p) with sign; 2x2: terms are two products.
  logic signed [CW-1:0] ma, mb, mc, md, top;
  logic [1:0] c1, c2;
  always_comb begin
    c1 = (ph_r == 2'd0) ? 2'd1 : 2'd0;
    c2 = (ph_r == 2'd2) ? 2'd1 : 2'd2;
    ma = el(rows_r, 2'd1, c1, rep_r);
    mb = el(rows_r, 2'd2, c2, rep_r);
    mc = el(rows_r, 2'd1, c2, rep_r);
    md = el(rows_r, 2'd2, c1, rep_r);
    top = el(rows_r, 2'd0, ph_r, rep_r);
    if (!three_r) begin
      ma = el(rows_r, 2'd0, 2'd0, rep_r);
      mb = el(rows_r, 2'd1, 2'd1, rep_r);
      mc = el(rows_r, 2'd0, 2'd1, rep_r);
      md = el(rows_r, 2'd1, 2'd0, rep_r);
    end
  end

  logic signed [PW-1:0] minor_c;
  logic signed [DW-1:0] prod_c;
  assign minor_c = PW'(ma * mb) - PW'(mc * md);
  assign prod_c  = DW'(top * minor_r);

  logic [DW-1:0] ad;
  assign ad = d_r[DW-1] ? DW'(-d_r) : DW'(d_r);

  logic signed [DW-1:0] djs;
  logic [DW-1:0] adj;
  logic [NW-1:0] dnum, dden;
  logic          dstart, dbusy, dbig;
  logic [SW+1:0] dq;
  assign djs  = dj_r[k_r];
  assign adj  = djs[DW-1] ? DW'(-djs) : DW'(djs);
  assign dnum = {adj, {crs_pkg::FRAC_BITS{1'b0}}};
  assign dden = NW'(ad);
  assign dstart = (st_r == S_DIV);

  crs_divider #(.NW(NW), .QW(SW + 2)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .busy(dbusy), .quo(dq), .big(dbig)
  );

  logic neg;
  logic [SW-1:0] qs;
  logic qo;
  assign neg = djs[DW-1] ^ d_r[DW-1];
  always_comb begin
    qo = 1'b0;
    if (neg) begin
      if (dbig || dq > (SW+2)'(33'h080000000)) begin
        qo = 1'b1; qs = {1'b1, {(SW-1){1'b0}}};
      end else qs = SW'(-dq);
    end else begin
      if (dbig || dq > (SW+2)'(33'h07FFFFFFF)) begin
        qo = 1'b1; qs = {1'b0, {(SW-1){1'b1}}};
      end else qs = dq[SW-1:0];
    end
  end

  logic [1:0] nlast;
  assign nlast = three_r ? 2'd2 : 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      rv_r <= 1'b0;
    end else begin
      if (rv_r && res_ready && st_r != S_OUT) rv_r <= 1'b0;
      case (st_r)
        S_IDLE: if (job_valid) begin
          rows_r <= job_rows; three_r <= job_ctl.three;
          rep_r <= 2'd3; ph_r <= 2'd0; acc_r <= '0;
          st_r <= S_MIN;
        end
        S_MIN: begin
          minor_r <= minor_c;
          if (!three_r) begin
            acc_r <= DW'(minor_c);
            ph_r  <= 2'd2;
            st_r  <= S_DET;
          end else st_r <= S_DET;
        end
        S_DET: begin
          logic signed [DW-1:0] a;
          a = three_r ? ((ph_r == 2'd1) ? acc_r - prod_c : acc_r + prod_c) : acc_r;
          if (ph_r == 2'd2 || !three_r) begin
            if (rep_r == 2'd3) d_r <= a; else dj_r[rep_r] <= a;
            ph_r <= 2'd0; acc_r <= '0;
            if (rep_r == nlast) st_r <= S_CHK;
            else begin
              rep_r <= (rep_r == 2'd3) ? 2'd0 : rep_r + 2'd1;
              st_r <= S_MIN;
            end
          end else begin
            acc_r <= a; ph_r <= ph_r + 2'd1; st_r <= S_MIN;
          end
        end
        S_CHK: begin
          sol_r[0] <= '0; sol_r[1] <= '0; sol_r[2] <= '0;
          ovf_r <= 1'b0; k_r <= 2'd0;
          if (ad == '0 || (ad[DW-1:crs_pkg::THR_WIDTH] == '0 &&
              ad[crs_pkg::THR_WIDTH-1:0] < thr)) begin
            sing_r <= 1'b1; st_r <= S_OUT;
          end else begin
            sing_r <= 1'b0; st_r <= S_DIV;
          end
        end
        S_DIV: st_r <= S_WAIT;
        S_WAIT: if (!dbusy) begin
          sol_r[k_r] <= qs; ovf_r <= ovf_r | qo;
          if (k_r == nlast) st_r <= S_OUT;
          else begin k_r <= k_r + 2'd1; st_r <= S_DIV; end
        end
        S_OUT: if (!rv_r || res_ready) begin
          rv_r <= 1'b1;
          res_data <= {ovf_r, sing_r, sol_r[2], sol_r[1], sol_r[0]};
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign job_ready = (st_r == S_IDLE);
  assign res_valid = rv_r;
endmodule
`default_nettype wire

### design/cramer_rule_solver_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Cramer's rule solver for 2x2 / 3x3 systems.
// in_ channel: one transfer per row; tdata = {rhs, coef_2, coef_1, coef_0},
//   coef_0 in the low bits, each COEF_WIDTH signed.
// out_ channel: one transfer per completed system; tdata holds sol_0, sol_1,
//   sol_2 (Q16.16) then singular and overflow, padded to 104 bits.
// cfg_: write enable, index (0 order, 1 singular_threshold), data.
// Write config only while idle.
// Each row is registered as it is accepted. A completed system goes to the
// solver through a one-entry job register; the solver steps through the
// minors and terms of each determinant in sequence and solves each unknown
// on one bit-serial divider.
// New rows are accepted while the solver works until the next system is full.
// A stalled out_tready holds the result; the solver then waits in its output
// step. Synchronous active-low reset clears row count, order=3, threshold=1.
module cramer_rule_solver_core #(
  parameter int COEF_WIDTH = crs_pkg::COEF_WIDTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire  [4*COEF_WIDTH-1:0] in_tdata,  // coef_0, coef_1, coef_2, rhs
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [103:0]       out_tdata,  // sol_0, sol_1, sol_2, singular, overflow
  input  wire                cfg_we,
  input  wire  [0:0]         cfg_index,
  input  wire  [31:0]        cfg_data
);
  logic [crs_pkg::ORDER_WIDTH-1:0] order_r;
  logic [crs_pkg::THR_WIDTH-1:0]   thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 2'd3;
      thr_r   <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        crs_pkg::REG_ORDER: order_r <= cfg_data[1:0];
        crs_pkg::REG_THR:   thr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic jv, jr, fr;
  crs_pkg::job_ctl_t jc;
  logic [12*COEF_WIDTH-1:0] jrows;
  logic [3*crs_pkg::SOL_WIDTH+1:0] rd;

  assign in_tready = fr;

  crs_front #(.CW(COEF_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && fr), .in_row(in_tdata),
    .order(order_r), .job_valid(jv), .job_ready(jr), .job_ctl(jc),
    .job_rows(jrows), .front_ready(fr)
  );

  crs_back #(.CW(COEF_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr), .job_ctl(jc),
    .job_rows(jrows), .thr(thr_r), .res_valid(out_tvalid), .res_ready(out_tready),
    .res_data(rd)
  );

  assign out_tdata = {6'd0, rd};
endmodule
`default_nettype wire

### tb/sv/cramer_rule_solver_core_tb.sv
`timescale 1ns / 1ps
module cramer_rule_solver_core_tb;

  localparam int CW = crs_pkg::COEF_WIDTH_DEF;
  // longest quiet stretch that a correct run can show: solve time,
  // the long receiver hold and the settle time before config writes
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 900;

  localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
  localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

  typedef struct {
    logic [31:0] sol_0;
    logic [31:0] sol_1;
    logic [31:0] sol_2;
    logic        singular;
    logic        overflow;
  } solution_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [4*CW-1:0] in_tdata = '0;  // coef_0, coef_1, coef_2, rhs
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [103:0] out_tdata;  // sol_0, sol_1, sol_2, singular, overflow
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state, mirrors the block
  logic [1:0] sys_order;
  logic [31:0] sing_thr;
  logic signed [CW-1:0] rows [3][4];
  int unsigned rows_held;

  solution_t pending_solutions[$];
  int errors = 0;
  bit quiet = 1'b0;      // no idling on either side
  bit hold_req = 1'b0;   // ask the receiver for a long hold-off
  int idle_cycles = 0;

  always #10 clk = ~clk;

  cramer_rule_solver_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // element (r,c) with column rep replaced by the right-hand side
  function automatic longint elem(int r, int c, int rep);
    return longint'(rows[r][(c == rep) ? 3 : c]);
  endfunction

  // exact determinant; 3x3 stays within 50 bits at 16-bit coefficients
  function automatic longint system_det(int n, int rep);
    longint m0, m1, m2;
    if (n == 2) begin
      return elem(0, 0, rep) * elem(1, 1, rep) - elem(0, 1, rep) * elem(1, 0, rep);
    end
    m0 = elem(1, 1, rep) * elem(2, 2, rep) - elem(1, 2, rep) * elem(2, 1, rep);
    m1 = elem(1, 0, rep) * elem(2, 2, rep) - elem(1, 2, rep) * elem(2, 0, rep);
    m2 = elem(1, 0, rep) * elem(2, 1, rep) - elem(1, 1, rep) * elem(2, 0, rep);
    return elem(0, 0, rep) * m0 - elem(0, 1, rep) * m1 + elem(0, 2, rep) * m2;
  endfunction

  // Q16.16 quotient, truncated toward zero, clamped
  function automatic logic [31:0] q16_quotient(longint dj, longint d, ref logic ovf);
    logic signed [127:0] num, den, q;
    num = 128'(signed'(dj)) <<< crs_pkg::FRAC_BITS;
    den = 128'(signed'(d));
    q = num / den;
    if (q > Q_MAX) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (q < Q_MIN) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  // stores one accepted row and queues a solution when the system is full
  task automatic predict_row(logic [4*CW-1:0] row);
    int n, r, k;
    longint d, ad;
    logic [31:0] sols [3];
    logic ovf;
    solution_t s;
    n = (sys_order < 2) ? 2 : int'(sys_order);
    r = (rows_held > 2) ? 2 : int'(rows_held);
    for (k = 0; k < 4; k++) rows[r][k] = row[k*CW +: CW];
    if (r + 1 < n) begin
      rows_held = r + 1;
      return;
    end
    rows_held = 0;
    d = system_det(n, -1);
    ad = (d < 0) ? -d : d;
    sols = '{32'd0, 32'd0, 32'd0};
    ovf = 1'b0;
    s.singular = (ad == 0) || (ad < longint'(sing_thr));
    if (!s.singular) begin
      for (k = 0; k < n; k++) sols[k] = q16_quotient(system_det(n, k), d, ovf);
    end
    s.sol_0 = sols[0];
    s.sol_1 = sols[1];
    s.sol_2 = sols[2];
    s.overflow = ovf;
    pending_solutions.push_back(s);
  endtask

  // one row transfer, with an optional random gap ahead of it
  task automatic send_row(logic signed [CW-1:0] c0, logic signed [CW-1:0] c1,
                          logic signed [CW-1:0] c2, logic signed [CW-1:0] rhs);
    logic [4*CW-1:0] row;
    row = {rhs, c2, c1, c0};
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= row;
    do @(posedge clk); while (!in_tready);
    predict_row(row);
  endtask

  // drain everything, then let any row still in flight settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == crs_pkg::REG_ORDER) sys_order = val[1:0];
    else sing_thr = val;
  endtask

  function automatic logic signed [CW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2: return CW'($signed($urandom_range(0, 2048)) - 1024);
      default: return CW'($urandom);
    endcase
  endfunction

  // scaled identity, extremes, zero matrix, and results near both Q16.16 limits
  task automatic test_order3_cases();
    write_reg(crs_pkg::REG_THR, 32'd1);
    send_row(16'sd256, 16'sd0, 16'sd0, 16'sd512);
    send_row(16'sd0, 16'sd256, 16'sd0, -16'sd768);
    send_row(16'sd0, 16'sd0, 16'sd256, 16'sh7FFF);
    send_row(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_row(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_row(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
    // zero determinant stays singular even with a zero threshold
    write_reg(crs_pkg::REG_THR, 32'd0);
    send_row(16'sd0, 16'sd0, 16'sd0, 16'sd5);
    send_row(16'sd0, 16'sd0, 16'sd0, 16'sd5);
    send_row(16'sd0, 16'sd0, 16'sd0, 16'sd5);
    // det 1 with large rhs gives results near the top and bottom of the range
    send_row(16'sd1, 16'sd0, 16'sd0, 16'sh7FFF);
    send_row(16'sd0, 16'sd1, 16'sd0, 16'sh8000);
    send_row(16'sd0, 16'sd0, 16'sd1, 16'sd1);
  endtask

  task automatic test_order2_cases();
    write_reg(crs_pkg::REG_ORDER, 2'd2);
    write_reg(crs_pkg::REG_THR, 32'hFFFF_FFFF);
    send_row(16'sd256, 16'sd256, 16'sh7FFF, 16'sd256);
    send_row(16'sd256, -16'sd256, 16'sh8000, 16'sd0);
    write_reg(crs_pkg::REG_THR, 32'd1);
    send_row(16'sd256, 16'sd256, 16'sh7FFF, 16'sd256);
    send_row(16'sd256, -16'sd256, 16'sh8000, 16'sd0);
    // orders below two behave as two
    write_reg(crs_pkg::REG_ORDER, 2'd0);
    send_row(16'sh8000, 16'sd3, 16'sd0, 16'sh7FFF);
    send_row(16'sd7, 16'sh7FFF, 16'sd0, 16'sh8000);
    write_reg(crs_pkg::REG_ORDER, 2'd1);
    send_row(16'sd2, 16'sd1, 16'sd9, 16'sd100);
    send_row(16'sd1, 16'sd2, 16'sd9, -16'sd100);
  endtask

  // order switched while a system is half collected
  task automatic test_order_switch();
    write_reg(crs_pkg::REG_ORDER, 2'd3);
    send_row(16'sd300, 16'sd20, 16'sd1, 16'sd400);
    send_row(-16'sd10, 16'sd200, 16'sd5, 16'sd40);
    write_reg(crs_pkg::REG_ORDER, 2'd2);
    send_row(16'sd1, 16'sd1, 16'sd1, 16'sd1);
    send_row(16'sd90, 16'sd3, 16'sd0, -16'sd7);
    write_reg(crs_pkg::REG_ORDER, 2'd3);
    send_row(16'sd5, 16'sd6, 16'sd7, 16'sd8);
    send_row(16'sd9, -16'sd2, 16'sd3, 16'sd4);
  endtask

  task automatic test_random(int unsigned n_items, bit with_hold);
    int i;
    for (i = 0; i < n_items; i++) begin
      if (with_hold && i == n_items / 3) hold_req = 1'b1;
      send_row(rand_coef(), rand_coef(), rand_coef(), rand_coef());
    end
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    solution_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_solutions.size() == 0) begin
        $display("%t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        e = pending_solutions.pop_front();
        if (out_tdata[31:0] !== e.sol_0)
          $display("%t: sol_0 exp %h got %h", $time, e.sol_0, out_tdata[31:0]);
        if (out_tdata[63:32] !== e.sol_1)
          $display("%t: sol_1 exp %h got %h", $time, e.sol_1, out_tdata[63:32]);
        if (out_tdata[95:64] !== e.sol_2)
          $display("%t: sol_2 exp %h got %h", $time, e.sol_2, out_tdata[95:64]);
        if (out_tdata[96] !== e.singular)
          $display("%t: singular exp %b got %b", $time, e.singular, out_tdata[96]);
        if (out_tdata[97] !== e.overflow)
          $display("%t: overflow exp %b got %b", $time, e.overflow, out_tdata[97]);
        if (out_tdata[97:0] !== {e.overflow, e.singular, e.sol_2, e.sol_1, e.sol_0})
          errors++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    sys_order = 2'd3;
    sing_thr = 32'd1;
    rows_held = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_order3_cases();
    test_order2_cases();
    test_order_switch();

    write_reg(crs_pkg::REG_THR, 32'd1);
    test_random(300, 1'b1);
    write_reg(crs_pkg::REG_ORDER, 2'd2);
    write_reg(crs_pkg::REG_THR, $urandom_range(1, 4096));
    test_random(250, 1'b0);
    write_reg(crs_pkg::REG_ORDER, 2'd3);
    write_reg(crs_pkg::REG_THR, 32'hFFFF_FFFF);
    test_random(150, 1'b0);
    write_reg(crs_pkg::REG_THR, $urandom);
    test_random(150, 1'b0);
    write_reg(crs_pkg::REG_ORDER, 2'd1);
    write_reg(crs_pkg::REG_THR, 32'd0);
    test_random(150, 1'b0);
    write_reg(crs_pkg::REG_ORDER, 2'd3);
    write_reg(crs_pkg::REG_THR, 32'd1);
    test_random(150, 1'b0);
    quiet = 1'b1;
    test_random(200, 1'b0);

    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
